// ===== rtl/mvt_pkg.sv =====
// ----------------------------------------------------------------------------
// mvt_pkg
// Shared types and constants for the 4x4 matrix-vector transform engine.
// ----------------------------------------------------------------------------
package mvt_pkg;

   localparam int WORD_W            = 32;
   localparam int LANES             = 4;
   localparam int SEL_W             = 2;
   localparam int DIM_DEFAULT       = 4;
   localparam int FRAC_BITS_DEFAULT = 16;

   // item modes
   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_XFORM = 1'b1;

   typedef logic signed [WORD_W-1:0] word_type;

   localparam word_type WORD_MAX = 32'sh7FFF_FFFF;
   localparam word_type WORD_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic             mode;
      logic [SEL_W-1:0] row;
      logic [SEL_W-1:0] col;
      word_type         element;
      word_type         vec_x;
      word_type         vec_y;
      word_type         vec_z;
      word_type         vec_w;
   } req_type;

   typedef struct packed {
      word_type out_x;
      word_type out_y;
      word_type out_z;
      word_type out_w;
      logic     saturated;
   } rsp_type;

   // per-stage pipeline control
   typedef struct packed {
      logic valid;
      logic advance;
   } stage_ctrl_type;

   // matrix element write
   typedef struct packed {
      logic             en;
      logic [SEL_W-1:0] row;
      logic [SEL_W-1:0] col;
      word_type         data;
   } mat_wr_type;

endpackage

// ===== rtl/mvt_matrix.sv =====
// ----------------------------------------------------------------------------
// mvt_matrix
// Coefficient store: DIM x DIM words, row-major, cleared by reset.
// ----------------------------------------------------------------------------
module mvt_matrix #(
   parameter int DIM = mvt_pkg::DIM_DEFAULT
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  mvt_pkg::mat_wr_type                      wr,
   output logic [DIM*DIM-1:0][mvt_pkg::WORD_W-1:0]  matrix
);

   logic [DIM*DIM-1:0][mvt_pkg::WORD_W-1:0] elem_ff;

   // rows or columns at DIM or above never match, so such loads drop out
   always_ff @(posedge clock) begin
      if (reset) begin
         elem_ff <= '0;
      end else if (wr.en) begin
         for (int r = 0; r < DIM; r++) begin
            for (int c = 0; c < DIM; c++) begin
               if (wr.row == mvt_pkg::SEL_W'(r) && wr.col == mvt_pkg::SEL_W'(c)) begin
                  elem_ff[r*DIM+c] <= wr.data;
               end
            end
         end
      end
   end

   assign matrix = elem_ff;

endmodule

// ===== rtl/mvt_product.sv =====
// ----------------------------------------------------------------------------
// mvt_product
// Multiply stage: DIM*DIM signed 32x32 products, scaled down by FRAC_BITS.
// ----------------------------------------------------------------------------
module mvt_product #(
   parameter int DIM       = mvt_pkg::DIM_DEFAULT,
   parameter int FRAC_BITS = mvt_pkg::FRAC_BITS_DEFAULT,
   localparam int PROD_W   = 2*mvt_pkg::WORD_W - FRAC_BITS
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  mvt_pkg::stage_ctrl_type                       ctrl,
   input  logic [mvt_pkg::LANES-1:0][mvt_pkg::WORD_W-1:0] vec,
   input  logic [DIM*DIM-1:0][mvt_pkg::WORD_W-1:0]       matrix,
   output logic                                          valid,
   output logic [DIM*DIM-1:0][PROD_W-1:0]                prod
);

   localparam int FULL_W = 2*mvt_pkg::WORD_W;

   logic                          valid_ff;
   logic [DIM*DIM-1:0][PROD_W-1:0] prod_in;
   logic [DIM*DIM-1:0][PROD_W-1:0] prod_ff;

   for (genvar k = 0; k < DIM*DIM; k++) begin : g_mul
      logic signed [FULL_W-1:0] full;
      assign full       = $signed(matrix[k]) * $signed(vec[k % DIM]);
      // dropping the low bits of a two's complement word rounds toward -inf
      assign prod_in[k] = full[FULL_W-1:FRAC_BITS];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctrl.advance) begin
         valid_ff <= ctrl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.advance && ctrl.valid) begin
         prod_ff <= prod_in;
      end
   end

   assign valid = valid_ff;
   assign prod  = prod_ff;

endmodule

// ===== rtl/mvt_sum.sv =====
// ----------------------------------------------------------------------------
// mvt_sum
// Row sums of the scaled products, saturated to 32 bits, into the result
// register.
// ----------------------------------------------------------------------------
module mvt_sum #(
   parameter int DIM       = mvt_pkg::DIM_DEFAULT,
   parameter int FRAC_BITS = mvt_pkg::FRAC_BITS_DEFAULT,
   localparam int PROD_W   = 2*mvt_pkg::WORD_W - FRAC_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  mvt_pkg::stage_ctrl_type        ctrl,
   input  logic [DIM*DIM-1:0][PROD_W-1:0] prod,
   output logic                           valid,
   output mvt_pkg::rsp_type               item
);

   // two guard bits cover a sum of up to four terms
   localparam int SUM_W = PROD_W + 2;
   localparam int HI_W  = SUM_W - mvt_pkg::WORD_W + 1;

   logic                                          valid_ff;
   mvt_pkg::rsp_type                              item_in;
   mvt_pkg::rsp_type                              item_ff;
   logic [mvt_pkg::LANES-1:0][mvt_pkg::WORD_W-1:0] lane_word;
   logic [mvt_pkg::LANES-1:0]                      lane_sat;

   for (genvar i = 0; i < mvt_pkg::LANES; i++) begin : g_lane
      if (i < DIM) begin : g_used
         logic signed [SUM_W-1:0] sum;
         logic        [HI_W-1:0]  hi;
         logic                    ovf;

         always_comb begin
            sum = '0;
            for (int j = 0; j < DIM; j++) begin
               sum = sum + SUM_W'($signed(prod[i*DIM+j]));
            end
         end

         // in range when every bit from bit 31 up equals the sign
         assign hi  = sum[SUM_W-1:mvt_pkg::WORD_W-1];
         assign ovf = !(&hi) && (|hi);

         assign lane_word[i] = !ovf ? sum[mvt_pkg::WORD_W-1:0] :
                               (sum[SUM_W-1] ? mvt_pkg::WORD_MIN : mvt_pkg::WORD_MAX);
         assign lane_sat[i] = ovf;
      end else begin : g_unused
         assign lane_word[i] = '0;
         assign lane_sat[i]  = 1'b0;
      end
   end

   always_comb begin
      item_in.out_x     = lane_word[0];
      item_in.out_y     = lane_word[1];
      item_in.out_z     = lane_word[2];
      item_in.out_w     = lane_word[3];
      item_in.saturated = |lane_sat;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctrl.advance) begin
         valid_ff <= ctrl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.advance && ctrl.valid) begin
         item_ff <= item_in;
      end
   end

   assign valid = valid_ff;
   assign item  = item_ff;

endmodule

// ===== rtl/matrix_vector_transform_4x4.sv =====
// ----------------------------------------------------------------------------
// matrix_vector_transform_4x4
// Vertex transform engine: holds a DIM x DIM Q16.16 matrix loaded one element
// per item and multiplies incoming vectors by it.
//
//   channel | ports                       | carries
//   --------+-----------------------------+-------------------------------
//   request | req_valid req_stall req_item| element load or vector
//   result  | rsp_valid rsp_stall rsp_item| transformed vector, sat flag
//
// One item per cycle while req_stall is low. A vector that is taken goes
// into the input register, then passes the product register (the 32x32
// multipliers) and the result register (row sum and saturation).
// A load item updates the matrix at acceptance and gives no result; a vector
// taken in the next cycle already sees it.
// Synchronous reset clears the matrix and empties the pipeline.
// Each stage holds under rsp_stall only while the stage after it is full;
// req_stall rises when all three stages are full and the result is stalled.
// ----------------------------------------------------------------------------
module matrix_vector_transform_4x4 #(
   parameter int DIM       = mvt_pkg::DIM_DEFAULT,
   parameter int FRAC_BITS = mvt_pkg::FRAC_BITS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  mvt_pkg::req_type req_item,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output mvt_pkg::rsp_type rsp_item
);

   localparam int PROD_W = 2*mvt_pkg::WORD_W - FRAC_BITS;

   logic                                          in_valid_ff;
   logic [mvt_pkg::LANES-1:0][mvt_pkg::WORD_W-1:0] vec_ff;
   logic [mvt_pkg::LANES-1:0][mvt_pkg::WORD_W-1:0] vec_in;
   logic                                          in_move;
   logic                                          prod_move;
   logic                                          rsp_move;
   logic                                          accept;
   logic                                          prod_valid;
   logic [DIM*DIM-1:0][PROD_W-1:0]                prod;
   logic [DIM*DIM-1:0][mvt_pkg::WORD_W-1:0]       matrix;
   mvt_pkg::mat_wr_type                           mat_wr;
   mvt_pkg::stage_ctrl_type                       prod_ctrl;
   mvt_pkg::stage_ctrl_type                       sum_ctrl;

   assign rsp_move  = !rsp_valid || !rsp_stall;
   assign prod_move = !prod_valid || rsp_move;
   assign in_move   = !in_valid_ff || prod_move;
   assign req_stall = !in_move;
   assign accept    = req_valid && in_move;

   assign mat_wr.en   = accept && (req_item.mode == mvt_pkg::MODE_LOAD);
   assign mat_wr.row  = req_item.row;
   assign mat_wr.col  = req_item.col;
   assign mat_wr.data = req_item.element;

   assign vec_in[0] = req_item.vec_x;
   assign vec_in[1] = req_item.vec_y;
   assign vec_in[2] = req_item.vec_z;
   assign vec_in[3] = req_item.vec_w;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_move) begin
         in_valid_ff <= accept && (req_item.mode == mvt_pkg::MODE_XFORM);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         vec_ff <= vec_in;
      end
   end

   assign prod_ctrl.valid   = in_valid_ff;
   assign prod_ctrl.advance = prod_move;
   assign sum_ctrl.valid    = prod_valid;
   assign sum_ctrl.advance  = rsp_move;

   mvt_matrix #(
      .DIM (DIM)
   ) u_matrix (
      .clock  (clock),
      .reset  (reset),
      .wr     (mat_wr),
      .matrix (matrix)
   );

   mvt_product #(
      .DIM       (DIM),
      .FRAC_BITS (FRAC_BITS)
   ) u_product (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (prod_ctrl),
      .vec    (vec_ff),
      .matrix (matrix),
      .valid  (prod_valid),
      .prod   (prod)
   );

   mvt_sum #(
      .DIM       (DIM),
      .FRAC_BITS (FRAC_BITS)
   ) u_sum (
      .clock (clock),
      .reset (reset),
      .ctrl  (sum_ctrl),
      .prod  (prod),
      .valid (rsp_valid),
      .item  (rsp_item)
   );

endmodule

// ===== rtl/mvt_checker.sv =====
// ----------------------------------------------------------------------------
// mvt_checker
// Port-level checks for the transform engine, bound to the top level.
// ----------------------------------------------------------------------------
module mvt_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input mvt_pkg::rsp_type rsp_item
);

   // pipeline is empty right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // requests only back up when the result side is holding a stalled item
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled while result side is free");

   // a saturated result has at least one element at a range limit
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.saturated) |->
         (rsp_item.out_x == mvt_pkg::WORD_MAX || rsp_item.out_x == mvt_pkg::WORD_MIN ||
          rsp_item.out_y == mvt_pkg::WORD_MAX || rsp_item.out_y == mvt_pkg::WORD_MIN ||
          rsp_item.out_z == mvt_pkg::WORD_MAX || rsp_item.out_z == mvt_pkg::WORD_MIN ||
          rsp_item.out_w == mvt_pkg::WORD_MAX || rsp_item.out_w == mvt_pkg::WORD_MIN))
      else $error("saturation flag without a clipped element");

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_item)))
      else $error("stalled result changed");

endmodule

bind matrix_vector_transform_4x4 mvt_checker u_mvt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_item  (rsp_item)
);
